// ===== sv/matrix_multiply_defines.svh =====
// assertion macros for the matrix multiply block
// expects clk_i and rst_ni in the scope of every use

`ifndef MATRIX_MULTIPLY_DEFINES_SVH
`define MATRIX_MULTIPLY_DEFINES_SVH

// same-cycle implication, off during reset
`define MM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define MM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/mm_pkg.sv =====
// shared types, constants and helpers for the matrix multiply block
// no dependencies
`timescale 1ns / 1ps

package mm_pkg;

  localparam int MaxDim  = 8;
  localparam int DimW    = 3;
  localparam int AddrW   = 2 * DimW;
  localparam int ElemW   = 16;
  localparam int ProdW   = 2 * ElemW;
  localparam int AccW    = 35;
  localparam int CfgW    = 4;
  localparam int CfgIdxW = 2;
  localparam int FuncW   = 2;
  localparam int QDepth  = 4;
  localparam int QAddrW  = 2;
  localparam int InDataW  = 24;
  localparam int OutDataW = 48;

  localparam logic [CfgIdxW-1:0] REG_OUT_ROWS  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_OUT_COLS  = 2'd2;

  localparam logic [FuncW-1:0] FUNC_LOAD_LEFT  = 2'd0;
  localparam logic [FuncW-1:0] FUNC_LOAD_RIGHT = 2'd1;
  localparam logic [FuncW-1:0] FUNC_COMPUTE    = 2'd2;

  typedef enum logic [1:0] {
    CMD_LOAD_LEFT,
    CMD_LOAD_RIGHT,
    CMD_COMPUTE
  } cmd_e;

  typedef struct packed {
    cmd_e                   kind;
    logic [DimW-1:0]        row;
    logic [DimW-1:0]        col;
    logic signed [ElemW-1:0] value;
  } cmd_t;

  // last index of each loop of the walk
  typedef struct packed {
    logic [DimW-1:0] nr;
    logic [DimW-1:0] nk;
    logic [DimW-1:0] nc;
  } dims_t;

  typedef struct packed {
    logic                   last;
    logic signed [AccW-1:0] value;
    logic [DimW-1:0]        col;
    logic [DimW-1:0]        row;
  } result_t;

  // clamp a dimension to 1..MaxDim and return its last index
  function automatic logic [DimW-1:0] dim_last(input logic [CfgW-1:0] v);
    logic [CfgW-1:0] r;
    if (v == '0) begin
      r = CfgW'(1);
    end else if (v > CfgW'(MaxDim)) begin
      r = CfgW'(MaxDim);
    end else begin
      r = v;
    end
    return DimW'(r - CfgW'(1));
  endfunction

endpackage

// ===== sv/mm_front.sv =====
// front end: takes input transactions and turns them into queue commands
// depends on mm_pkg
`timescale 1ns / 1ps

module mm_front import mm_pkg::*; (
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [InDataW-1:0] s_axis_tdata,
  input  logic [FuncW-1:0]   s_axis_tuser,
  input  logic               q_full_i,
  output logic               q_push_o,
  output cmd_t               q_cmd_o
);

  logic keep;

  assign s_axis_tready = !q_full_i;

  always_comb begin
    q_cmd_o.row   = s_axis_tdata[DimW-1:0];
    q_cmd_o.col   = s_axis_tdata[2*DimW-1:DimW];
    q_cmd_o.value = s_axis_tdata[2*DimW+ElemW-1:2*DimW];
    q_cmd_o.kind  = CMD_LOAD_LEFT;
    keep          = 1'b1;
    unique case (s_axis_tuser)
      FUNC_LOAD_LEFT:  q_cmd_o.kind = CMD_LOAD_LEFT;
      FUNC_LOAD_RIGHT: q_cmd_o.kind = CMD_LOAD_RIGHT;
      FUNC_COMPUTE:    q_cmd_o.kind = CMD_COMPUTE;
      default:         keep = 1'b0;
    endcase
  end

  // unused selector is accepted and dropped
  assign q_push_o = s_axis_tvalid && !q_full_i && keep;

endmodule

// ===== sv/mm_queue.sv =====
// four-entry command queue between the front end and the compute engine
// depends on mm_pkg
`timescale 1ns / 1ps

module mm_queue import mm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  input  logic pop_i,
  output cmd_t head_o,
  output logic full_o,
  output logic empty_o
);

  cmd_t              q_mem_q [QDepth];
  logic [QAddrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QAddrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QAddrW:0]   count_q, count_d;

  assign full_o  = (count_q == (QAddrW+1)'(QDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = q_mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      q_mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== sv/mm_back.sv =====
// compute engine: element stores, multiply-accumulate walk and output register
// depends on mm_pkg and matrix_multiply_defines.svh
`timescale 1ns / 1ps
`include "matrix_multiply_defines.svh"

module mm_back import mm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  dims_t   dims_i,
  input  logic    cmd_valid_i,
  input  cmd_t    cmd_i,
  output logic    cmd_pop_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_data_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WAIT  = 2'd1;
  localparam logic [1:0] ST_ISSUE = 2'd2;

  logic [1:0]      state_q, state_d;
  dims_t           dims_q, dims_d;
  logic [DimW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic            issue;

  logic signed [ElemW-1:0] left_mem  [MaxDim*MaxDim];
  logic signed [ElemW-1:0] right_mem [MaxDim*MaxDim];
  logic signed [ElemW-1:0] left_rd_q, right_rd_q;
  logic                    we_left, we_right;
  logic [AddrW-1:0]        waddr;

  logic                    s1_v_q, s2_v_q;
  logic                    s1_first_q, s1_klast_q, s2_first_q, s2_klast_q;
  logic                    s1_elast_q, s2_elast_q;
  logic [DimW-1:0]         s1_row_q, s1_col_q, s2_row_q, s2_col_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q, acc_sum;
  logic                    out_load;
  logic                    out_valid_q;
  result_t                 out_q;

  always_comb begin
    state_d   = state_q;
    dims_d    = dims_q;
    i_d       = i_q;
    j_d       = j_q;
    k_d       = k_q;
    issue     = 1'b0;
    cmd_pop_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.kind == CMD_COMPUTE) begin
            dims_d  = dims_i;
            i_d     = '0;
            j_d     = '0;
            k_d     = '0;
            state_d = ST_WAIT;
          end
        end
      end
      ST_WAIT: begin
        if (!s1_v_q && !s2_v_q && (!out_valid_q || out_ready_i)) begin
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        issue = 1'b1;
        if (k_q == dims_q.nk) begin
          k_d = '0;
          if (j_q == dims_q.nc) begin
            j_d = '0;
            if (i_q == dims_q.nr) begin
              state_d = ST_IDLE;
            end else begin
              i_d     = i_q + 1'b1;
              state_d = ST_WAIT;
            end
          end else begin
            j_d     = j_q + 1'b1;
            state_d = ST_WAIT;
          end
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      dims_q  <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      dims_q  <= dims_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  // element stores, row-major
  assign we_left  = cmd_pop_o && (cmd_i.kind == CMD_LOAD_LEFT);
  assign we_right = cmd_pop_o && (cmd_i.kind == CMD_LOAD_RIGHT);
  assign waddr    = {cmd_i.row, cmd_i.col};

  always_ff @(posedge clk_i) begin
    if (we_left) begin
      left_mem[waddr] <= cmd_i.value;
    end
    if (issue) begin
      left_rd_q <= left_mem[{k_q, j_q}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_right) begin
      right_mem[waddr] <= cmd_i.value;
    end
    if (issue) begin
      right_rd_q <= right_mem[{i_q, k_q}];
    end
  end

  // read, multiply, accumulate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= issue;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_first_q <= (k_q == '0);
      s1_klast_q <= (k_q == dims_q.nk);
      s1_elast_q <= (i_q == dims_q.nr) && (j_q == dims_q.nc);
      s1_row_q   <= i_q;
      s1_col_q   <= j_q;
    end
    if (s1_v_q) begin
      prod_q     <= right_rd_q * left_rd_q;
      s2_first_q <= s1_first_q;
      s2_klast_q <= s1_klast_q;
      s2_elast_q <= s1_elast_q;
      s2_row_q   <= s1_row_q;
      s2_col_q   <= s1_col_q;
    end
    if (s2_v_q) begin
      acc_q <= acc_sum;
    end
  end

  assign acc_sum = (s2_first_q ? '0 : acc_q) +
                   {{(AccW-ProdW){prod_q[ProdW-1]}}, prod_q};
  assign out_load = s2_v_q && s2_klast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.last  <= s2_elast_q;
      out_q.value <= acc_sum;
      out_q.col   <= s2_col_q;
      out_q.row   <= s2_row_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `MM_ASSERT_IMP(a_out_free, out_load, !out_valid_q || out_ready_i, "result overwrites pending output")
  `MM_ASSERT_IMP(a_issue_out_empty, state_q == ST_ISSUE, !out_valid_q, "issue with output pending")
  `MM_ASSERT_NEXT(a_pipe_flow, s1_v_q, s2_v_q, "multiply stage lost a term")

endmodule

// ===== sv/matrix_multiply.sv =====
// top level of the matrix multiply block: dimension registers and stream ports
// depends on mm_pkg, mm_front, mm_queue and mm_back
`timescale 1ns / 1ps

// Load transactions (tuser 0 left, 1 right) write one element each and are taken one per
// cycle through a four-entry command queue while it has room; tuser 3 is taken and ignored.
// A compute transaction (tuser 2) produces out_rows*out_cols results in row-major order,
// tlast on the final one, product = right * left over inner_dim terms. Results come one at
// a time from the single multiply-accumulate walk over one read port of each element store;
// it starts none while the output register waits on m_axis_tready. Dimension registers read
// 0 as 1 and values above 8 as 8 and are sampled when the compute transaction starts.

module matrix_multiply import mm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // row_index, col_index, elem_value, zero pad
  input  logic [FuncW-1:0]    s_axis_tuser,   // func
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // out_row, out_col, product_value, zero pad
  output logic                m_axis_tlast,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgW-1:0]     cfg_data_i
);

  logic [CfgW-1:0] out_rows_q, inner_dim_q, out_cols_q;
  dims_t           dims;
  logic            q_push, q_pop, q_full, q_empty;
  cmd_t            q_cmd, q_head;
  result_t         res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_rows_q  <= CfgW'(MaxDim);
      inner_dim_q <= CfgW'(MaxDim);
      out_cols_q  <= CfgW'(MaxDim);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_OUT_ROWS:  out_rows_q  <= cfg_data_i;
        REG_INNER_DIM: inner_dim_q <= cfg_data_i;
        REG_OUT_COLS:  out_cols_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign dims.nr = dim_last(out_rows_q);
  assign dims.nk = dim_last(inner_dim_q);
  assign dims.nc = dim_last(out_cols_q);

  mm_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_cmd_o       (q_cmd)
  );

  mm_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_cmd),
    .pop_i      (q_pop),
    .head_o     (q_head),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  mm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dims_i      (dims),
    .cmd_valid_i (!q_empty),
    .cmd_i       (q_head),
    .cmd_pop_o   (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (res)
  );

  assign m_axis_tdata = {(OutDataW-AccW-2*DimW)'(0), res.value, res.col, res.row};
  assign m_axis_tlast = res.last;

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for the matrix multiply block: loads, computes and checks products
// depends on mm_pkg and matrix_multiply
`timescale 1ns / 1ps

module tb import mm_pkg::*;;

  localparam int SettleCycles = 40;
  localparam int ItemTarget   = 380;
  localparam logic [FuncW-1:0]   FuncUnused = 2'd3;
  localparam logic [CfgIdxW-1:0] RegSpare   = 2'd3;

  typedef struct {
    logic [2:0]  row;
    logic [2:0]  col;
    logic [34:0] value;
    logic        last;
  } product_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;   // row_index, col_index, elem_value, zero pad
  logic [FuncW-1:0]    s_axis_tuser;   // func
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;   // out_row, out_col, product_value, zero pad
  logic                m_axis_tlast;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgW-1:0]     cfg_data_i;

  // shadow copy of the block state
  logic signed [15:0] left_mat  [8][8];
  logic signed [15:0] right_mat [8][8];
  logic [3:0]         rows_reg;
  logic [3:0]         inner_reg;
  logic [3:0]         cols_reg;

  product_t expected_products[$];
  int       fail_count;
  int       accepted_items;
  bit       s_idle_en;
  bit       m_stall_en;

  matrix_multiply DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("matrix_multiply regression: fail");
    $finish;
  end

  function automatic int effective_dim(input logic [3:0] v);
    if (v == 4'd0) begin
      return 1;
    end else if (v > 4'd8) begin
      return 8;
    end
    return int'(v);
  endfunction

  function automatic void predict_products(input logic [FuncW-1:0] func, input logic [2:0] row,
                                           input logic [2:0] col, input logic signed [15:0] val);
    int       nr;
    int       nk;
    int       nc;
    longint   acc;
    product_t p;
    case (func)
      FUNC_LOAD_LEFT: begin
        left_mat[row][col] = val;
      end
      FUNC_LOAD_RIGHT: begin
        right_mat[row][col] = val;
      end
      FUNC_COMPUTE: begin
        nr = effective_dim(rows_reg);
        nk = effective_dim(inner_reg);
        nc = effective_dim(cols_reg);
        for (int i = 0; i < nr; i++) begin
          for (int j = 0; j < nc; j++) begin
            acc = 0;
            for (int k = 0; k < nk; k++) begin
              acc += longint'(right_mat[i][k]) * longint'(left_mat[k][j]);
            end
            p.row   = 3'(i);
            p.col   = 3'(j);
            p.value = acc[34:0];
            p.last  = (i == nr - 1) && (j == nc - 1);
            expected_products.push_back(p);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic signed [15:0] rand_elem();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [3:0] pick_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return 4'($urandom_range(1, 3));
    end else if (r < 85) begin
      return 4'($urandom_range(4, 8));
    end else if (r < 93) begin
      return 4'd0;
    end
    return 4'($urandom_range(9, 15));
  endfunction

  // leaves tvalid high after the transaction so a following item can go out back to back
  task automatic send_item(input logic [FuncW-1:0] func, input logic [2:0] row,
                           input logic [2:0] col, input logic signed [15:0] val);
    while (s_idle_en && $urandom_range(0, 99) < 9) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, val, col, row};
    s_axis_tuser  <= func;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_products(func, row, col, val);
    if (func != FuncUnused) begin
      accepted_items++;
    end
  endtask

  task automatic pause_until_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_products.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_dims(input logic [3:0] r, input logic [3:0] k, input logic [3:0] c);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_OUT_ROWS;
    cfg_data_i  <= r;
    @(posedge clk_i);
    cfg_index_i <= REG_INNER_DIM;
    cfg_data_i  <= k;
    @(posedge clk_i);
    cfg_index_i <= REG_OUT_COLS;
    cfg_data_i  <= c;
    @(posedge clk_i);
    // write to the spare index must change nothing
    cfg_index_i <= RegSpare;
    cfg_data_i  <= 4'($urandom);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    rows_reg  = r;
    inner_reg = k;
    cols_reg  = c;
  endtask

  task automatic test_reset_default();
    for (int r = 0; r < 8; r++) begin
      for (int c = 0; c < 8; c++) begin
        send_item(FUNC_LOAD_LEFT, 3'(r), 3'(c), 16'sh8000);
      end
    end
    for (int r = 0; r < 8; r++) begin
      for (int c = 0; c < 8; c++) begin
        send_item(FUNC_LOAD_RIGHT, 3'(r), 3'(c), 16'sh8000);
      end
    end
    send_item(FUNC_COMPUTE, 3'd0, 3'd0, 16'sh0000);
    pause_until_drained();
  endtask

  task automatic test_element_extremes();
    set_dims(4'd1, 4'd1, 4'd1);
    send_item(FUNC_LOAD_LEFT, 3'd0, 3'd0, 16'sh8000);
    send_item(FUNC_LOAD_RIGHT, 3'd0, 3'd0, 16'sh8000);
    send_item(FUNC_COMPUTE, 3'd7, 3'd7, 16'shffff);
    send_item(FUNC_LOAD_LEFT, 3'd0, 3'd0, 16'sh7fff);
    send_item(FUNC_COMPUTE, 3'd0, 3'd0, 16'sh0000);
    send_item(FUNC_LOAD_RIGHT, 3'd0, 3'd0, 16'sh7fff);
    send_item(FUNC_LOAD_LEFT, 3'd7, 3'd7, 16'sh7fff);
    send_item(FUNC_COMPUTE, 3'd0, 3'd0, 16'sh0000);
    pause_until_drained();
  endtask

  task automatic test_ignored_func();
    send_item(FuncUnused, 3'd0, 3'd0, 16'sh1234);
    send_item(FuncUnused, 3'd7, 3'd7, 16'shffff);
    send_item(FUNC_COMPUTE, 3'd0, 3'd0, 16'sh0000);
    pause_until_drained();
  endtask

  task automatic test_dim_clamp();
    set_dims(4'd0, 4'd0, 4'd0);
    send_item(FUNC_COMPUTE, 3'd0, 3'd0, 16'sh0000);
    pause_until_drained();
    set_dims(4'd15, 4'd9, 4'd12);
    send_item(FUNC_LOAD_RIGHT, 3'd7, 3'd0, 16'sh7fff);
    send_item(FUNC_LOAD_LEFT, 3'd0, 3'd7, 16'sh1111);
    send_item(FUNC_COMPUTE, 3'd0, 3'd0, 16'sh0000);
    pause_until_drained();
    set_dims(4'd8, 4'd1, 4'd8);
    send_item(FUNC_COMPUTE, 3'd0, 3'd0, 16'sh0000);
    pause_until_drained();
  endtask

  task automatic test_random_sequences();
    int seq;
    int nr;
    int nk;
    int nc;
    int n_loads;
    seq = 0;
    while (accepted_items < ItemTarget) begin
      // a stretch with no idling on either side
      s_idle_en  = !(seq >= 8 && seq < 16);
      m_stall_en = !(seq >= 8 && seq < 16);
      if (seq == 0 || $urandom_range(0, 1) == 0) begin
        pause_until_drained();
        set_dims(pick_dim(), pick_dim(), pick_dim());
      end
      nr = effective_dim(rows_reg);
      nk = effective_dim(inner_reg);
      nc = effective_dim(cols_reg);
      if (nr * nk + nk * nc <= 24 && $urandom_range(0, 3) != 0) begin
        for (int i = 0; i < nr; i++) begin
          for (int k = 0; k < nk; k++) begin
            send_item(FUNC_LOAD_RIGHT, 3'(i), 3'(k), rand_elem());
          end
        end
        for (int k = 0; k < nk; k++) begin
          for (int j = 0; j < nc; j++) begin
            send_item(FUNC_LOAD_LEFT, 3'(k), 3'(j), rand_elem());
          end
        end
      end else begin
        n_loads = $urandom_range(1, 12);
        for (int n = 0; n < n_loads; n++) begin
          send_item($urandom_range(0, 1) ? FUNC_LOAD_LEFT : FUNC_LOAD_RIGHT,
                    3'($urandom), 3'($urandom), rand_elem());
        end
      end
      if ($urandom_range(0, 4) == 0) begin
        send_item(FuncUnused, 3'($urandom), 3'($urandom), 16'($urandom));
      end
      send_item(FUNC_COMPUTE, 3'($urandom), 3'($urandom), 16'($urandom));
      seq++;
    end
    s_idle_en  = 1'b1;
    m_stall_en = 1'b1;
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= !(m_stall_en && $urandom_range(0, 99) < 9);
  end

  always @(posedge clk_i) begin : check_products
    product_t    want;
    logic [2:0]  got_row;
    logic [2:0]  got_col;
    logic [34:0] got_value;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_row   = m_axis_tdata[2:0];
      got_col   = m_axis_tdata[5:3];
      got_value = m_axis_tdata[40:6];
      if (expected_products.size() == 0) begin
        $error("unexpected result transaction: row %0d col %0d value %0d",
               got_row, got_col, $signed(got_value));
        fail_count++;
      end else begin
        want = expected_products.pop_front();
        if (got_row !== want.row) begin
          $error("out_row mismatch: expected %0d, got %0d", want.row, got_row);
          fail_count++;
        end
        if (got_col !== want.col) begin
          $error("out_col mismatch: expected %0d, got %0d", want.col, got_col);
          fail_count++;
        end
        if (got_value !== want.value) begin
          $error("product_value mismatch: expected %0d, got %0d",
                 $signed(want.value), $signed(got_value));
          fail_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last mismatch: expected %0d, got %0d", want.last, m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  initial begin
    fail_count     = 0;
    accepted_items = 0;
    s_idle_en      = 1'b1;
    m_stall_en     = 1'b1;
    rows_reg       = 4'd8;
    inner_reg      = 4'd8;
    cols_reg       = 4'd8;
    for (int r = 0; r < 8; r++) begin
      for (int c = 0; c < 8; c++) begin
        left_mat[r][c]  = '0;
        right_mat[r][c] = '0;
      end
    end
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    m_axis_tready <= 1'b1;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_default();
    test_element_extremes();
    test_ignored_func();
    test_dim_clamp();
    test_random_sequences();
    pause_until_drained();

    if (fail_count == 0) begin
      $display("matrix_multiply regression: pass");
    end else begin
      $display("matrix_multiply regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/mm_pkg.sv
sv/mm_front.sv
sv/mm_queue.sv
sv/mm_back.sv
sv/matrix_multiply.sv
tb/tb.sv
